// ===== rtl/hcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hcb_pkg;

  localparam int MAX_LEAVES  = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int NODES       = 2 * MAX_LEAVES - 1;
  localparam int IDX_W       = $clog2(NODES);
  localparam int CNT_W       = $clog2(MAX_LEAVES + 1);
  localparam int LEAF_W      = $clog2(MAX_LEAVES);
  localparam int CODE_W      = MAX_LEAVES - 1;
  localparam int LEN_W       = $clog2(MAX_LEAVES);
  localparam int NODE_W      = WEIGHT_BITS + $clog2(MAX_LEAVES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_EMIT
  } state_e;

  // running two-minimum search token passed cell to cell
  typedef struct packed {
    logic              valid;
    logic              have1;
    logic [IDX_W-1:0]  idx1;
    logic [NODE_W-1:0] w1;
    logic              have2;
    logic [IDX_W-1:0]  idx2;
    logic [NODE_W-1:0] w2;
  } carry_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [NODE_W-1:0] weight;
  } load_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [IDX_W-1:0]  parent;
    logic [NODE_W-1:0] weight;
  } merge_t;

endpackage
`default_nettype wire

// ===== rtl/hcb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hcb_req_if;
  import hcb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   last_weight;
  modport source(output valid, weight, last_weight, input ready);
  modport sink(input valid, weight, last_weight, output ready);
endinterface

interface hcb_code_if;
  import hcb_pkg::*;
  logic              valid;
  logic              ready;
  logic [LEAF_W-1:0] leaf_number;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              last_code;
  modport source(output valid, leaf_number, code_bits, code_length, last_code, input ready);
  modport sink(input valid, leaf_number, code_bits, code_length, last_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/hcb_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hcb_cell
  import hcb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire load_t            load_i,
  input  wire merge_t           merge_i,
  input  wire logic             clear_i,
  input  wire carry_t           carry_i,
  output carry_t                carry_o,
  output logic [CODE_W-1:0]     code_o,
  output logic [LEN_W-1:0]      len_o
);

  logic              pending_q, pending_d;
  logic [NODE_W-1:0] weight_q, weight_d;
  logic [IDX_W-1:0]  group_q, group_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [LEN_W-1:0]  len_q, len_d;
  carry_t            carry_q, carry_d;
  logic [CODE_W-1:0] bit_pos;

  assign bit_pos = CODE_W'(1) << len_q;

  always_comb begin
    pending_d = pending_q;
    weight_d  = weight_q;
    group_d   = group_q;
    code_d    = code_q;
    len_d     = len_q;
    if (clear_i) begin
      pending_d = 1'b0;
    end else if (load_i.en && load_i.idx == cell_idx_i) begin
      pending_d = 1'b1;
      weight_d  = load_i.weight;
      group_d   = cell_idx_i;
      code_d    = '0;
      len_d     = '0;
    end else if (merge_i.en) begin
      if (merge_i.parent == cell_idx_i) begin
        pending_d = 1'b1;
        weight_d  = merge_i.weight;
      end else if (merge_i.lo == cell_idx_i || merge_i.hi == cell_idx_i) begin
        pending_d = 1'b0;
      end
      // prepend the new root-side bit above the bits gathered so far
      if (group_q == merge_i.lo) begin
        group_d = merge_i.parent;
        len_d   = len_q + LEN_W'(1);
      end else if (group_q == merge_i.hi) begin
        group_d = merge_i.parent;
        code_d  = code_q | bit_pos;
        len_d   = len_q + LEN_W'(1);
      end
    end
  end

  // cells are scanned in ascending order, so a tie never displaces an older node
  always_comb begin
    carry_d = carry_i;
    if (merge_i.en) begin
      carry_d.valid = 1'b0;
    end else if (carry_i.valid && pending_q) begin
      if (!carry_i.have1 || weight_q < carry_i.w1) begin
        carry_d.have2 = carry_i.have1;
        carry_d.idx2  = carry_i.idx1;
        carry_d.w2    = carry_i.w1;
        carry_d.have1 = 1'b1;
        carry_d.idx1  = cell_idx_i;
        carry_d.w1    = weight_q;
      end else if (!carry_i.have2 || weight_q < carry_i.w2) begin
        carry_d.have2 = 1'b1;
        carry_d.idx2  = cell_idx_i;
        carry_d.w2    = weight_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      carry_q   <= '0;
    end else begin
      pending_q <= pending_d;
      carry_q   <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q <= weight_d;
    group_q  <= group_d;
    code_q   <= code_d;
    len_q    <= len_d;
  end

  assign carry_o = carry_q;
  assign code_o  = code_q;
  assign len_o   = len_q;

endmodule
`default_nettype wire

// ===== rtl/huffman_code_builder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Leaf weights: one per cycle while idle.
// Build: each merge sends a search token down the node cells, and the merge is taken
// from the token as it leaves the cell of the newest node.
// Codes: one per cycle after the build while the receiver is ready, in leaf order.
// Reset (async, active low) clears the counts, pending flags and handshake state.
module huffman_code_builder
  import hcb_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hcb_req_if.sink    req_i,
  hcb_code_if.source code_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  leaf_cnt_q, leaf_cnt_d;
  logic [IDX_W-1:0]  node_cnt_q, node_cnt_d;
  logic [CNT_W-1:0]  pend_q, pend_d;
  logic [CNT_W-1:0]  emit_q, emit_d;
  logic              ovalid_q, ovalid_d;
  logic [LEAF_W-1:0] onum_q, onum_d;
  logic [CODE_W-1:0] ocode_q, ocode_d;
  logic [LEN_W-1:0]  olen_q, olen_d;
  logic              olast_q, olast_d;

  load_t  load;
  merge_t merge;
  logic   clear;
  carry_t inject;
  carry_t tap;
  logic   req_take;
  logic   emit_last;

  carry_t            carry_in [NODES];
  carry_t            carry_out[NODES];
  logic [CODE_W-1:0] cell_code[NODES];
  logic [LEN_W-1:0]  cell_len [NODES];

  for (genvar g = 0; g < NODES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign carry_in[g] = inject;
    end else begin : g_link
      assign carry_in[g] = carry_out[g-1];
    end
    hcb_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_idx_i(IDX_W'(g)),
      .load_i    (load),
      .merge_i   (merge),
      .clear_i   (clear),
      .carry_i   (carry_in[g]),
      .carry_o   (carry_out[g]),
      .code_o    (cell_code[g]),
      .len_o     (cell_len[g])
    );
  end

  assign tap         = carry_out[node_cnt_q - IDX_W'(1)];
  assign req_i.ready = (state_q == S_IDLE);
  assign req_take    = req_i.valid && req_i.ready;
  assign emit_last   = (emit_q == leaf_cnt_q - CNT_W'(1));

  always_comb begin
    state_d    = state_q;
    leaf_cnt_d = leaf_cnt_q;
    node_cnt_d = node_cnt_q;
    pend_d     = pend_q;
    emit_d     = emit_q;
    ovalid_d   = ovalid_q;
    onum_d     = onum_q;
    ocode_d    = ocode_q;
    olen_d     = olen_q;
    olast_d    = olast_q;
    load       = '0;
    merge      = '0;
    clear      = 1'b0;
    inject     = '0;

    if (ovalid_q && code_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_take) begin
          if (leaf_cnt_q < CNT_W'(MAX_LEAVES)) begin
            load.en     = 1'b1;
            load.idx    = node_cnt_q;
            load.weight = NODE_W'(req_i.weight);
            leaf_cnt_d  = leaf_cnt_q + CNT_W'(1);
            node_cnt_d  = node_cnt_q + IDX_W'(1);
          end
          if (req_i.last_weight) begin
            pend_d  = leaf_cnt_d;
            emit_d  = '0;
            state_d = (leaf_cnt_d > CNT_W'(1)) ? S_SCAN : S_EMIT;
          end
        end
      end
      S_SCAN: begin
        inject.valid = 1'b1;
        state_d      = S_WAIT;
      end
      S_WAIT: begin
        if (tap.valid) begin
          merge.en     = 1'b1;
          merge.lo     = (tap.idx1 < tap.idx2) ? tap.idx1 : tap.idx2;
          merge.hi     = (tap.idx1 < tap.idx2) ? tap.idx2 : tap.idx1;
          merge.parent = node_cnt_q;
          merge.weight = tap.w1 + tap.w2;
          node_cnt_d   = node_cnt_q + IDX_W'(1);
          pend_d       = pend_q - CNT_W'(1);
          state_d      = (pend_q == CNT_W'(2)) ? S_EMIT : S_SCAN;
        end
      end
      S_EMIT: begin
        if (!ovalid_q || code_o.ready) begin
          ovalid_d = 1'b1;
          onum_d   = emit_q[LEAF_W-1:0];
          ocode_d  = cell_code[emit_q[LEAF_W-1:0]];
          olen_d   = cell_len[emit_q[LEAF_W-1:0]];
          olast_d  = emit_last;
          emit_d   = emit_q + CNT_W'(1);
          if (emit_last) begin
            clear      = 1'b1;
            leaf_cnt_d = '0;
            node_cnt_d = '0;
            state_d    = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      leaf_cnt_q <= '0;
      node_cnt_q <= '0;
      pend_q     <= '0;
      emit_q     <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      leaf_cnt_q <= leaf_cnt_d;
      node_cnt_q <= node_cnt_d;
      pend_q     <= pend_d;
      emit_q     <= emit_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    onum_q  <= onum_d;
    ocode_q <= ocode_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
  end

  assign code_o.valid       = ovalid_q;
  assign code_o.leaf_number = onum_q;
  assign code_o.code_bits   = ocode_q;
  assign code_o.code_length = olen_q;
  assign code_o.last_code   = olast_q;

`ifndef SYNTHESIS
  a_wait_two_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WAIT |-> pend_q >= CNT_W'(2))
    else $error("search running with fewer than two pending nodes");
  a_merge_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge.en |-> (tap.have1 && tap.have2 && merge.lo != merge.hi))
    else $error("merge without two distinct minima");
  a_merge_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge.en |=> node_cnt_q == $past(node_cnt_q) + IDX_W'(1))
    else $error("node count did not advance on merge");
`endif

endmodule
`default_nettype wire
